### sv/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register-transfer master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 256;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] dev_addr;
        logic       is_read;
        logic       skip_reg_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] load_byte;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
        logic [7:0] bytes_left;
    } t_res;

endpackage
`default_nettype wire

### sv/i2cm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic       is_read;
    logic       skip_reg_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] load_byte;
    logic       sda_in;

    modport source (
        output valid, req_type, dev_addr, is_read, skip_reg_addr, reg_addr,
               byte_count, load_byte, sda_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, dev_addr, is_read, skip_reg_addr, reg_addr,
               byte_count, load_byte, sda_in,
        output ready
    );
endinterface
`default_nettype wire

### sv/i2cm_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_res_if
// Result channel: valid/ready handshake with the bus levels and status.
// ----------------------------------------------------------------------------
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [7:0] bytes_left;

    modport source (
        output valid, scl_out, sda_out, read_byte, read_valid, busy_res,
               done_res, bytes_left,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, read_byte, read_valid, busy_res,
               done_res, bytes_left,
        output ready
    );
endinterface
`default_nettype wire

### sv/i2cm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### sv/i2cm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_core
// Bus phase sequencer: one request per accepted transaction, write buffer
// held in RAM, next data byte prefetched through the registered read port.
// ----------------------------------------------------------------------------
module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire t_req          i_req,
    output t_res               o_res,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]    i_rd_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_ST_A, S_ST_B, S_ST_C,
        S_TX_LO, S_TX_HI, S_AK_LO, S_AK_HI,
        S_RX_LO, S_RX_HI, S_RA_LO, S_RA_HI,
        S_SP_A, S_SP_B, S_SP_C,
        S_RS_A, S_RS_B, S_RS_C
    } t_state;

    typedef enum logic [1:0] {
        K_ADDR_W, K_REG, K_DATA, K_ADDR_R
    } t_kind;

    localparam logic [AW-1:0] LAST_PTR = AW'(BUFFER_DEPTH - 1);

    t_state        r_state, n_state;
    t_kind         r_kind, n_kind;
    logic [3:0]    r_bit, n_bit;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_rem, n_rem;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_ld_ptr, n_ld_ptr;
    logic [6:0]    r_dev, n_dev;
    logic [7:0]    r_reg, n_reg;
    logic          r_rd, n_rd;
    logic          r_skip, n_skip;
    logic          r_pend, n_pend;   // shift byte still sits in RAM read data

    logic          start_tx;
    t_kind         tx_kind;
    logic [7:0]    eff_shift;
    logic [7:0]    rem_dec;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    assign eff_shift = r_pend ? i_rd_data : r_shift;
    assign rem_dec   = r_rem - 8'd1;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_rd_ptr = r_rd_ptr;
        n_ld_ptr = r_ld_ptr;
        n_dev    = r_dev;
        n_reg    = r_reg;
        n_rd     = r_rd;
        n_skip   = r_skip;
        n_pend   = r_pend;
        start_tx = 1'b0;
        tx_kind  = K_ADDR_W;
        o_wr_en  = 1'b0;
        o_res    = '0;
        o_res.scl_out = 1'b1;
        o_res.sda_out = 1'b1;

        if (i_fire) begin
            unique case (i_req.req_type)
                REQ_LOAD: begin
                    if (r_state == S_IDLE) begin
                        o_wr_en  = 1'b1;
                        n_ld_ptr = ptr_inc(r_ld_ptr);
                    end
                end
                REQ_START: begin
                    if (r_state == S_IDLE) begin
                        n_dev    = i_req.dev_addr;
                        n_rd     = i_req.is_read;
                        n_skip   = i_req.skip_reg_addr;
                        n_reg    = i_req.reg_addr;
                        n_rem    = i_req.byte_count;
                        n_rd_ptr = '0;
                        n_bit    = '0;
                        n_shift  = '0;
                        n_pend   = 1'b0;
                        n_state  = S_ST_A;
                    end
                end
                REQ_TICK: begin
                    unique case (r_state)
                        S_IDLE: ;
                        S_ST_A, S_RS_A: begin
                            o_res.scl_out = 1'b0;
                            n_state = (r_state == S_ST_A) ? S_ST_B : S_RS_B;
                        end
                        S_ST_B, S_RS_B: begin
                            n_state = (r_state == S_ST_B) ? S_ST_C : S_RS_C;
                        end
                        S_ST_C: begin
                            o_res.sda_out = 1'b0;
                            start_tx = 1'b1;
                            tx_kind  = (r_rd && r_skip) ? K_ADDR_R : K_ADDR_W;
                        end
                        S_RS_C: begin
                            o_res.sda_out = 1'b0;
                            start_tx = 1'b1;
                            tx_kind  = K_ADDR_R;
                        end
                        S_TX_LO: begin
                            o_res.scl_out = 1'b0;
                            o_res.sda_out = eff_shift[7];
                            n_shift = eff_shift;
                            n_pend  = 1'b0;
                            n_state = S_TX_HI;
                        end
                        S_TX_HI: begin
                            o_res.sda_out = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            n_state = n_bit[3] ? S_AK_LO : S_TX_LO;
                        end
                        S_AK_LO: begin
                            o_res.scl_out = 1'b0;
                            n_state = S_AK_HI;
                        end
                        S_AK_HI: begin
                            if (i_req.sda_in) begin
                                n_state = S_SP_A;
                            end else begin
                                case (r_kind)
                                    K_ADDR_W: begin
                                        if (!r_rd && r_skip) begin
                                            if (r_rem == '0) begin
                                                n_state = S_SP_A;
                                            end else begin
                                                start_tx = 1'b1;
                                                tx_kind  = K_DATA;
                                            end
                                        end else begin
                                            start_tx = 1'b1;
                                            tx_kind  = K_REG;
                                        end
                                    end
                                    K_REG: begin
                                        if (r_rd) begin
                                            n_state = S_RS_A;
                                        end else if (r_rem == '0) begin
                                            n_state = S_SP_A;
                                        end else begin
                                            start_tx = 1'b1;
                                            tx_kind  = K_DATA;
                                        end
                                    end
                                    K_DATA: begin
                                        n_rem    = rem_dec;
                                        n_rd_ptr = ptr_inc(r_rd_ptr);
                                        if (rem_dec == '0) begin
                                            n_state = S_SP_A;
                                        end else begin
                                            start_tx = 1'b1;
                                            tx_kind  = K_DATA;
                                        end
                                    end
                                    default: begin
                                        if (r_rem == '0) begin
                                            n_state = S_SP_A;
                                        end else begin
                                            n_bit   = '0;
                                            n_shift = '0;
                                            n_state = S_RX_LO;
                                        end
                                    end
                                endcase
                            end
                        end
                        S_RX_LO: begin
                            o_res.scl_out = 1'b0;
                            n_state = S_RX_HI;
                        end
                        S_RX_HI: begin
                            n_shift = {r_shift[6:0], i_req.sda_in};
                            n_bit   = r_bit + 4'd1;
                            n_state = n_bit[3] ? S_RA_LO : S_RX_LO;
                        end
                        S_RA_LO: begin
                            o_res.scl_out = 1'b0;
                            o_res.sda_out = (r_rem == 8'd1);
                            n_state = S_RA_HI;
                        end
                        S_RA_HI: begin
                            o_res.sda_out    = (r_rem == 8'd1);
                            o_res.read_byte  = r_shift;
                            o_res.read_valid = 1'b1;
                            n_rem = rem_dec;
                            if (rem_dec == '0) begin
                                n_state = S_SP_A;
                            end else begin
                                n_bit   = '0;
                                n_shift = '0;
                                n_state = S_RX_LO;
                            end
                        end
                        S_SP_A: begin
                            o_res.scl_out = 1'b0;
                            o_res.sda_out = 1'b0;
                            n_state = S_SP_B;
                        end
                        S_SP_B: begin
                            o_res.sda_out = 1'b0;
                            n_state = S_SP_C;
                        end
                        S_SP_C: begin
                            o_res.done_res = 1'b1;
                            n_ld_ptr = '0;
                            n_state  = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase

                    if (start_tx) begin
                        n_kind  = tx_kind;
                        n_bit   = '0;
                        n_pend  = (tx_kind == K_DATA);
                        n_state = S_TX_LO;
                        case (tx_kind)
                            K_ADDR_W: n_shift = {r_dev, 1'b0};
                            K_REG:    n_shift = r_reg;
                            K_ADDR_R: n_shift = {r_dev, 1'b1};
                            default:  n_shift = '0;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        o_res.busy_res   = (n_state != S_IDLE);
        o_res.bytes_left = n_rem;
    end

    assign o_wr_addr = r_ld_ptr;
    assign o_wr_data = i_req.load_byte;
    // address the next data byte from the next-state pointer, ahead of its first bus phase
    assign o_rd_addr = n_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_ADDR_W;
            r_bit    <= '0;
            r_shift  <= '0;
            r_rem    <= '0;
            r_rd_ptr <= '0;
            r_ld_ptr <= '0;
            r_dev    <= '0;
            r_reg    <= '0;
            r_rd     <= 1'b0;
            r_skip   <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_rem    <= n_rem;
            r_rd_ptr <= n_rd_ptr;
            r_ld_ptr <= n_ld_ptr;
            r_dev    <= n_dev;
            r_reg    <= n_reg;
            r_rd     <= n_rd;
            r_skip   <= n_skip;
            r_pend   <= n_pend;
        end
    end

    a_pend_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_TX_LO) && (r_kind == K_DATA))
        else $error("prefetch pending outside first data phase");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit counter out of range");

    a_stop_clears_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_req.req_type == REQ_TICK) && (r_state == S_SP_C)
        |=> (r_state == S_IDLE) && (r_ld_ptr == '0))
        else $error("stop did not return to idle with empty buffer");

    a_busy_load_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_req.req_type == REQ_LOAD) && (r_state != S_IDLE)
        |=> $stable(r_ld_ptr))
        else $error("load taken while busy");

endmodule
`default_nettype wire

### sv/i2cm_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_skid
// Two-entry output register: keeps input open while one result is stalled.
// ----------------------------------------------------------------------------
module i2cm_skid
    import i2cm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_res i_data,
    output logic      o_ready,
    i2cm_res_if.source o_res
);

    logic r_main_valid;
    logic r_skid_valid;
    t_res r_main;
    t_res r_skid;

    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || o_res.ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || o_res.ready) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_res.valid      = r_main_valid;
    assign o_res.scl_out    = r_main.scl_out;
    assign o_res.sda_out    = r_main.sda_out;
    assign o_res.read_byte  = r_main.read_byte;
    assign o_res.read_valid = r_main.read_valid;
    assign o_res.busy_res   = r_main.busy_res;
    assign o_res.done_res   = r_main.done_res;
    assign o_res.bytes_left = r_main.bytes_left;

endmodule
`default_nettype wire

### sv/i2c_master_register_transfer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// I2C master for register-style read and write transfers, one bus half-bit
// phase per tick request.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output register has room and
// returns one result per request: the phase sequencer works out the result
// in the cycle of acceptance and a two-entry output register holds it, so
// requests keep flowing while one result waits. Load requests write the byte
// buffer RAM; the next data byte is read from it ahead of its first bus
// phase, so the RAM's read latency never stalls a tick. Results report the
// SCL/SDA levels for the phase, received bytes, busy, done and the count of
// data bytes not yet moved.
module i2c_master_register_transfer
    import i2cm_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cm_req_if.sink    i_req,
    i2cm_res_if.source  o_res
);

    t_req          req;
    t_res          res;
    logic          fire;
    logic          in_ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign req.req_type      = i_req.req_type;
    assign req.dev_addr      = i_req.dev_addr;
    assign req.is_read       = i_req.is_read;
    assign req.skip_reg_addr = i_req.skip_reg_addr;
    assign req.reg_addr      = i_req.reg_addr;
    assign req.byte_count    = i_req.byte_count;
    assign req.load_byte     = i_req.load_byte;
    assign req.sda_in        = i_req.sda_in;

    assign i_req.ready = in_ready;
    assign fire        = i_req.valid && in_ready;

    i2cm_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_req     (req),
        .o_res     (res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    i2cm_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    i2cm_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire),
        .i_data  (res),
        .o_ready (in_ready),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

### bench/i2c_master_register_transfer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_tb
// Self-checking bench for the I2C register-transfer master. A cycle-level
// bus-phase predictor tracks every accepted request and queues the result it
// must produce; a checker compares each returned result field by field.
// Directed transfers cover both directions, the skip option, zero and full
// counts, NACKs at each stage, ignored requests and buffer wrap. Random
// traffic with ACK/NACK and noise requests follows. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_tb;
    import i2cm_pkg::*;

    localparam logic [1:0] REQ_RSVD = 2'd3;

    // bus phase encoding
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_A    = 5'd1;
    localparam logic [4:0] PH_ST_B    = 5'd2;
    localparam logic [4:0] PH_ST_C    = 5'd3;
    localparam logic [4:0] PH_TX_BASE = 5'd4;
    localparam logic [4:0] PH_RX_LO   = 5'd20;
    localparam logic [4:0] PH_RX_HI   = 5'd21;
    localparam logic [4:0] PH_RA_LO   = 5'd22;
    localparam logic [4:0] PH_RA_HI   = 5'd23;
    localparam logic [4:0] PH_SP_A    = 5'd24;
    localparam logic [4:0] PH_SP_B    = 5'd25;
    localparam logic [4:0] PH_SP_C    = 5'd26;
    localparam logic [4:0] PH_RS_A    = 5'd27;
    localparam logic [4:0] PH_RS_B    = 5'd28;
    localparam logic [4:0] PH_RS_C    = 5'd29;

    // byte kinds shifted out by the master
    localparam int unsigned KIND_ADDR_W = 0;
    localparam int unsigned KIND_REG    = 1;
    localparam int unsigned KIND_DATA   = 2;
    localparam int unsigned KIND_ADDR_R = 3;

    localparam int unsigned BUF_DEPTH   = BUFFER_DEPTH_DEF;
    localparam int          STALL_LIMIT = 1000;
    localparam int          IDLE_PCT    = 32;

    logic i_clk;
    logic i_rst_n;

    i2cm_req_if req_if ();
    i2cm_res_if res_if ();

    i2c_master_register_transfer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // predicted master state
    logic [4:0] bus_phase  = PH_IDLE;
    logic [3:0] bit_cnt    = '0;
    logic [7:0] shift_reg  = '0;
    logic [7:0] remain_cnt = '0;
    logic [7:0] rd_ptr     = '0;
    logic [7:0] ld_ptr     = '0;
    logic [6:0] dev_lat    = '0;
    logic [7:0] reg_lat    = '0;
    logic       mode_rd    = 1'b0;
    logic       mode_skip  = 1'b0;
    logic [7:0] wbuf [BUF_DEPTH];
    bit         wbuf_loaded [BUF_DEPTH];

    t_res expected_results [$];
    bit   failed        = 1'b0;
    bit   no_idle       = 1'b0;
    int   live_requests = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void load_shifter(int unsigned kind);
        case (kind)
            KIND_ADDR_W: shift_reg = {dev_lat, 1'b0};
            KIND_REG:    shift_reg = reg_lat;
            KIND_DATA:   shift_reg = wbuf[rd_ptr];
            default:     shift_reg = {dev_lat, 1'b1};
        endcase
        bit_cnt   = '0;
        bus_phase = PH_TX_BASE + 5'(kind * 4);
    endfunction

    function automatic void data_or_stop();
        if (remain_cnt == 8'd0) begin
            bus_phase = PH_SP_A;
        end else begin
            load_shifter(KIND_DATA);
        end
    endfunction

    function automatic void after_ack(int unsigned kind, logic nack);
        if (nack) begin
            bus_phase = PH_SP_A;
        end else begin
            case (kind)
                KIND_ADDR_W: begin
                    if (!mode_rd && mode_skip) data_or_stop();
                    else load_shifter(KIND_REG);
                end
                KIND_REG: begin
                    if (mode_rd) bus_phase = PH_RS_A;
                    else data_or_stop();
                end
                KIND_DATA: begin
                    remain_cnt = remain_cnt - 8'd1;
                    rd_ptr     = rd_ptr + 8'd1;
                    data_or_stop();
                end
                default: begin
                    if (remain_cnt == 8'd0) begin
                        bus_phase = PH_SP_A;
                    end else begin
                        bit_cnt   = '0;
                        shift_reg = '0;
                        bus_phase = PH_RX_LO;
                    end
                end
            endcase
        end
    endfunction

    function automatic t_res bus_model_step(t_req r);
        t_res        o;
        logic [4:0]  p;
        logic [1:0]  sub;
        int unsigned kind;
        o         = '0;
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        p         = bus_phase;
        case (r.req_type)
            REQ_LOAD: begin
                if (p == PH_IDLE) begin
                    wbuf[ld_ptr]        = r.load_byte;
                    wbuf_loaded[ld_ptr] = 1'b1;
                    ld_ptr              = ld_ptr + 8'd1;
                end
            end
            REQ_START: begin
                if (p == PH_IDLE) begin
                    dev_lat    = r.dev_addr;
                    mode_rd    = r.is_read;
                    mode_skip  = r.skip_reg_addr;
                    reg_lat    = r.reg_addr;
                    remain_cnt = r.byte_count;
                    rd_ptr     = '0;
                    bit_cnt    = '0;
                    shift_reg  = '0;
                    bus_phase  = PH_ST_A;
                end
            end
            REQ_TICK: begin
                if (p >= PH_TX_BASE && p < PH_RX_LO) begin
                    kind = (p - PH_TX_BASE) >> 2;
                    sub  = p[1:0];
                    case (sub)
                        2'd0: begin
                            o.scl_out = 1'b0;
                            o.sda_out = shift_reg[7];
                            bus_phase = p + 5'd1;
                        end
                        2'd1: begin
                            o.sda_out = shift_reg[7];
                            shift_reg = shift_reg << 1;
                            bit_cnt   = bit_cnt + 4'd1;
                            bus_phase = (bit_cnt >= 4'd8) ? p + 5'd1 : p - 5'd1;
                        end
                        2'd2: begin
                            o.scl_out = 1'b0;
                            bus_phase = p + 5'd1;
                        end
                        default: after_ack(kind, r.sda_in);
                    endcase
                end else begin
                    case (p)
                        PH_ST_A, PH_RS_A: begin
                            o.scl_out = 1'b0;
                            bus_phase = p + 5'd1;
                        end
                        PH_ST_B, PH_RS_B: bus_phase = p + 5'd1;
                        PH_ST_C: begin
                            o.sda_out = 1'b0;
                            load_shifter((mode_rd && mode_skip) ? KIND_ADDR_R : KIND_ADDR_W);
                        end
                        PH_RS_C: begin
                            o.sda_out = 1'b0;
                            load_shifter(KIND_ADDR_R);
                        end
                        PH_RX_LO: begin
                            o.scl_out = 1'b0;
                            bus_phase = PH_RX_HI;
                        end
                        PH_RX_HI: begin
                            shift_reg = {shift_reg[6:0], r.sda_in};
                            bit_cnt   = bit_cnt + 4'd1;
                            bus_phase = (bit_cnt >= 4'd8) ? PH_RA_LO : PH_RX_LO;
                        end
                        PH_RA_LO: begin
                            // NACK only the last byte
                            o.scl_out = 1'b0;
                            o.sda_out = (remain_cnt == 8'd1);
                            bus_phase = PH_RA_HI;
                        end
                        PH_RA_HI: begin
                            o.sda_out    = (remain_cnt == 8'd1);
                            o.read_byte  = shift_reg;
                            o.read_valid = 1'b1;
                            remain_cnt   = remain_cnt - 8'd1;
                            if (remain_cnt == 8'd0) begin
                                bus_phase = PH_SP_A;
                            end else begin
                                bit_cnt   = '0;
                                shift_reg = '0;
                                bus_phase = PH_RX_LO;
                            end
                        end
                        PH_SP_A: begin
                            o.scl_out = 1'b0;
                            o.sda_out = 1'b0;
                            bus_phase = PH_SP_B;
                        end
                        PH_SP_B: begin
                            o.sda_out = 1'b0;
                            bus_phase = PH_SP_C;
                        end
                        PH_SP_C: begin
                            o.done_res = 1'b1;
                            bus_phase  = PH_IDLE;
                            ld_ptr     = '0;
                        end
                        default: bus_phase = PH_IDLE;
                    endcase
                end
            end
            default: ;
        endcase
        o.busy_res   = (bus_phase != PH_IDLE);
        o.bytes_left = remain_cnt;
        return o;
    endfunction

    // number of buffer entries loaded at least once, counted from entry 0
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < BUF_DEPTH && wbuf_loaded[n]) n++;
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    function automatic t_req random_req(logic [1:0] kind);
        t_req r;
        r.req_type      = kind;
        r.dev_addr      = 7'($urandom);
        r.is_read       = 1'($urandom);
        r.skip_reg_addr = 1'($urandom);
        r.reg_addr      = 8'($urandom);
        r.byte_count    = 8'($urandom);
        r.load_byte     = 8'($urandom);
        r.sda_in        = 1'($urandom);
        return r;
    endfunction

    task automatic send_item(input t_req item);
        t_req r;
        bit   live;
        r = item;
        // a write never runs past the bytes loaded so far
        if (r.req_type == REQ_START && bus_phase == PH_IDLE && !r.is_read
                && r.byte_count > loaded_prefix()) begin
            r.byte_count = 8'(loaded_prefix());
        end
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.req_type;
        req_if.dev_addr      <= r.dev_addr;
        req_if.is_read       <= r.is_read;
        req_if.skip_reg_addr <= r.skip_reg_addr;
        req_if.reg_addr      <= r.reg_addr;
        req_if.byte_count    <= r.byte_count;
        req_if.load_byte     <= r.load_byte;
        req_if.sda_in        <= r.sda_in;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        live = (r.req_type == REQ_TICK) ? (bus_phase != PH_IDLE)
                                        : (r.req_type != REQ_RSVD && bus_phase == PH_IDLE);
        if (live) live_requests++;
        expected_results.push_back(bus_model_step(r));
    endtask

    task automatic do_load(input logic [7:0] data);
        t_req r;
        r           = random_req(REQ_LOAD);
        r.load_byte = data;
        send_item(r);
    endtask

    task automatic do_start(input logic [6:0] dev, input logic rd, input logic skip,
                            input logic [7:0] regno, input logic [7:0] cnt);
        t_req r;
        r               = random_req(REQ_START);
        r.dev_addr      = dev;
        r.is_read       = rd;
        r.skip_reg_addr = skip;
        r.reg_addr      = regno;
        r.byte_count    = cnt;
        send_item(r);
    endtask

    // Tick until the transfer ends. ACK slots are numbered from 0; the one at
    // nack_slot is NACKed, the rest NACKed at nack_pct. Ignored requests are
    // mixed in at noise_pct.
    task automatic run_bus(input int nack_slot, input int nack_pct, input int noise_pct);
        t_req r;
        int   slot;
        int   pick;
        slot = 0;
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                pick = $urandom_range(2);
                r = random_req(pick == 0 ? REQ_LOAD : (pick == 1 ? REQ_START : REQ_RSVD));
            end else begin
                r = random_req(REQ_TICK);
                if (bus_phase >= PH_TX_BASE && bus_phase < PH_RX_LO
                        && bus_phase[1:0] == 2'd3) begin
                    r.sda_in = (slot == nack_slot) || ($urandom_range(99) < nack_pct);
                    slot++;
                end
            end
            send_item(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_write_transfers();
        do_load(8'h00);
        do_load(8'hFF);
        do_load(8'hA5);
        do_start(7'h7F, 1'b0, 1'b0, 8'h00, 8'd3);
        run_bus(-1, 0, 0);
        do_start(7'h00, 1'b0, 1'b1, 8'hFF, 8'd2);
        run_bus(-1, 0, 0);
    endtask

    task automatic test_read_transfers();
        do_start(7'h55, 1'b1, 1'b0, 8'hFF, 8'd2);
        run_bus(-1, 0, 0);
        do_start(7'h2A, 1'b1, 1'b1, 8'h5A, 8'd1);
        run_bus(-1, 0, 0);
    endtask

    task automatic test_zero_count();
        do_start(7'h11, 1'b0, 1'b0, 8'h80, 8'd0);
        run_bus(-1, 0, 0);
        do_start(7'h22, 1'b0, 1'b1, 8'h01, 8'd0);
        run_bus(-1, 0, 0);
        do_start(7'h33, 1'b1, 1'b0, 8'h7F, 8'd0);
        run_bus(-1, 0, 0);
        do_start(7'h44, 1'b1, 1'b1, 8'hC3, 8'd0);
        run_bus(-1, 0, 0);
    endtask

    task automatic test_nack_handling();
        // address, register, read address after repeated START, first data byte
        do_start(7'h50, 1'b0, 1'b0, 8'h10, 8'd3);
        run_bus(0, 0, 0);
        do_start(7'h51, 1'b1, 1'b0, 8'h20, 8'd3);
        run_bus(1, 0, 0);
        do_start(7'h52, 1'b1, 1'b0, 8'h30, 8'd3);
        run_bus(2, 0, 0);
        do_start(7'h53, 1'b0, 1'b0, 8'h40, 8'd3);
        run_bus(2, 0, 0);
    endtask

    task automatic test_ignored_requests();
        t_req r;
        r = random_req(REQ_TICK);
        r.sda_in = 1'b0;
        send_item(r);
        r.sda_in = 1'b1;
        send_item(r);
        send_item(random_req(REQ_RSVD));
        send_item(random_req(REQ_RSVD));
        // loads and starts during a transfer must not disturb it
        do_start(7'h3C, 1'b0, 1'b0, 8'h99, 8'd2);
        run_bus(-1, 0, 40);
        do_start(7'h3D, 1'b1, 1'b0, 8'h66, 8'd2);
        run_bus(-1, 0, 40);
    endtask

    task automatic test_buffer_wrap();
        repeat (BUF_DEPTH + 2) do_load(8'($urandom));
        do_start(7'h60, 1'b0, 1'b0, 8'hE0, 8'd3);
        run_bus(-1, 0, 0);
        // load pointer restarts at 0 after STOP
        do_load(8'h3C);
        do_start(7'h61, 1'b0, 1'b1, 8'h00, 8'd1);
        run_bus(-1, 0, 0);
    endtask

    task automatic test_full_count();
        do_start(7'h70, 1'b0, 1'b0, 8'hAA, 8'd255);
        run_bus(3, 0, 0);
        // read cut off at its address byte; the full count still shows in bytes_left
        do_start(7'h71, 1'b1, 1'b0, 8'h55, 8'd255);
        run_bus(2, 0, 0);
    endtask

    task automatic test_random_traffic(input int n_items, input bit burst);
        int   target;
        int   cnt;
        t_req r;
        no_idle = burst;
        target  = live_requests + n_items;
        while (live_requests < target) begin
            if ($urandom_range(99) < 85) begin
                repeat (($urandom_range(99) < 10) ? $urandom_range(40) : $urandom_range(6))
                    do_load(8'($urandom));
                cnt = ($urandom_range(99) < 8) ? $urandom_range(40) : $urandom_range(5);
                do_start(7'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 8'(cnt));
            end else begin
                r = random_req(2'($urandom));
                r.byte_count = 8'($urandom_range(7));
                send_item(r);
            end
            run_bus(-1, 6, 5);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : res_check
        t_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with none expected");
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                check_field("scl_out", 8'(e.scl_out), 8'(res_if.scl_out));
                check_field("sda_out", 8'(e.sda_out), 8'(res_if.sda_out));
                check_field("read_byte", e.read_byte, res_if.read_byte);
                check_field("read_valid", 8'(e.read_valid), 8'(res_if.read_valid));
                check_field("busy_res", 8'(e.busy_res), 8'(res_if.busy_res));
                check_field("done_res", 8'(e.done_res), 8'(res_if.done_res));
                check_field("bytes_left", e.bytes_left, res_if.bytes_left);
            end
        end
        res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // no transaction on either channel for too long ends the run
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("i2c_master_register_transfer_tb: FAIL");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.req_type      <= REQ_LOAD;
        req_if.dev_addr      <= '0;
        req_if.is_read       <= 1'b0;
        req_if.skip_reg_addr <= 1'b0;
        req_if.reg_addr      <= '0;
        req_if.byte_count    <= '0;
        req_if.load_byte     <= '0;
        req_if.sda_in        <= 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_write_transfers();
        test_read_transfers();
        test_zero_count();
        test_nack_handling();
        test_ignored_requests();
        test_buffer_wrap();
        test_full_count();
        test_random_traffic(100, 1'b1);
        test_random_traffic(300, 1'b0);

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (!failed) begin
            $display("i2c_master_register_transfer_tb: PASS");
        end else begin
            $display("i2c_master_register_transfer_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
sv/i2cm_pkg.sv
sv/i2cm_req_if.sv
sv/i2cm_res_if.sv
sv/i2cm_ram.sv
sv/i2cm_core.sv
sv/i2cm_skid.sv
sv/i2c_master_register_transfer.sv
bench/i2c_master_register_transfer_tb.sv
